// ===== hw/rtl/bcd_pkg.sv =====
// Package for the BC1/BC2/BC3 block decoder: format codes, register indexes,
// the front-to-back queue entry and the constant-divide helpers.
// No dependencies.
`default_nettype none

package bcd_pkg;

	localparam logic [1:0] FMT_BC1 = 2'd0;
	localparam logic [1:0] FMT_BC2 = 2'd1;
	localparam logic [1:0] FMT_BC3 = 2'd2;
	localparam logic [1:0] FMT_BC3_ALT = 2'd3;

	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_SWAP   = 1'b1;

	localparam logic [3:0] LAST_TEXEL = 4'hF;

	// One decoded block, ready to be expanded into texels.
	typedef struct packed {
		logic [1:0]       fmt;
		logic [3:0][23:0] cpal;   // {r, g, b}
		logic [7:0][7:0]  apal;
		logic [31:0]      cidx;   // 2 bits per texel
		logic [63:0]      aidx;   // BC2: 4 bits per texel, BC3: 3 bits per texel
	} bcd_entry_t;

	function automatic logic [63:0] swap_pairs(input logic [63:0] x);
		return ((x & 64'h00FF00FF00FF00FF) << 8) | ((x >> 8) & 64'h00FF00FF00FF00FF);
	endfunction

	// floor(v * 255 / 31) via reciprocal multiply, exact over 0..31
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [12:0] x;
		logic [28:0] p;
		x = {v, 8'd0} - {8'd0, v};
		p = 29'(x) * 29'(33826);
		return p[27:20];
	endfunction

	// floor(v * 255 / 63), exact over 0..63
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [13:0] x;
		logic [28:0] p;
		x = {v, 8'd0} - {8'd0, v};
		p = 29'(x) * 29'(16645);
		return p[27:20];
	endfunction

	// floor(x / 3) for x <= 765
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'(683);
		return p[18:11];
	endfunction

	// floor(x / 7) for x <= 1785
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(2341);
		return p[21:14];
	endfunction

	// floor(x / 5) for x <= 1275
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(3277);
		return p[21:14];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bcd_front.sv =====
// Front end: takes block words, applies the byte-pair swap, expands endpoints
// and builds both palettes over two stages. Uses bcd_pkg.
`default_nettype none

module bcd_front
	import bcd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [63:0]  in_lo,
	input  wire logic [63:0]  in_hi,
	input  wire logic [1:0]   block_format,
	input  wire logic         swap_byte_pairs,
	output logic              out_valid,
	input  wire logic         out_ready,
	output bcd_entry_t        out_entry
);

	logic        v_s1;
	logic [63:0] lo_s1, hi_s1;
	logic [1:0]  fmt_s1;

	logic        v_s2;
	logic [1:0]  fmt_s2;
	logic        three_s2;
	logic [7:0]  r0_s2, g0_s2, b0_s2, r1_s2, g1_s2, b1_s2;
	logic [31:0] cidx_s2;
	logic [63:0] aw_s2;
	logic [10:0] asum7_s2 [1:6];
	logic [10:0] asum5_s2 [1:4];

	logic        ready_s1, ready_s2;
	logic [63:0] cw;
	logic [15:0] c0, c1;
	logic [10:0] asum7 [1:6];
	logic [10:0] asum5 [1:4];

	assign ready_s2  = !v_s2 || out_ready;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = v_s2;

	// stage 1: swap and capture; format 3 decodes as BC3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			lo_s1  <= swap_byte_pairs ? swap_pairs(in_lo) : in_lo;
			hi_s1  <= swap_byte_pairs ? swap_pairs(in_hi) : in_hi;
			fmt_s1 <= (block_format == FMT_BC3_ALT) ? FMT_BC3 : block_format;
		end
	end

	// endpoint expansion and BC3 weighted alpha sums
	always_comb begin
		cw = (fmt_s1 == FMT_BC1) ? lo_s1 : hi_s1;
		c0 = cw[15:0];
		c1 = cw[31:16];
		for (int i = 1; i <= 6; i++) begin
			asum7[i] = 11'((7 - i) * lo_s1[7:0]) + 11'(i * lo_s1[15:8]);
		end
		for (int i = 1; i <= 4; i++) begin
			asum5[i] = 11'((5 - i) * lo_s1[7:0]) + 11'(i * lo_s1[15:8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			fmt_s2   <= fmt_s1;
			three_s2 <= (fmt_s1 == FMT_BC1) && (c0 <= c1);
			r0_s2    <= expand5(c0[15:11]);
			g0_s2    <= expand6(c0[10:5]);
			b0_s2    <= expand5(c0[4:0]);
			r1_s2    <= expand5(c1[15:11]);
			g1_s2    <= expand6(c1[10:5]);
			b1_s2    <= expand5(c1[4:0]);
			cidx_s2  <= cw[63:32];
			aw_s2    <= lo_s1;
			asum7_s2 <= asum7;
			asum5_s2 <= asum5;
		end
	end

	// stage 2: interpolated palette entries
	always_comb begin
		out_entry         = '0;
		out_entry.fmt     = fmt_s2;
		out_entry.cidx    = cidx_s2;
		out_entry.cpal[0] = {r0_s2, g0_s2, b0_s2};
		out_entry.cpal[1] = {r1_s2, g1_s2, b1_s2};
		if (!three_s2) begin
			out_entry.cpal[2] = {
				div3({1'b0, r0_s2, 1'b0} + {2'b0, r1_s2}),
				div3({1'b0, g0_s2, 1'b0} + {2'b0, g1_s2}),
				div3({1'b0, b0_s2, 1'b0} + {2'b0, b1_s2})};
			out_entry.cpal[3] = {
				div3({2'b0, r0_s2} + {1'b0, r1_s2, 1'b0}),
				div3({2'b0, g0_s2} + {1'b0, g1_s2, 1'b0}),
				div3({2'b0, b0_s2} + {1'b0, b1_s2, 1'b0})};
		end else begin
			out_entry.cpal[2] = {
				8'((9'(r0_s2) + 9'(r1_s2)) >> 1),
				8'((9'(g0_s2) + 9'(g1_s2)) >> 1),
				8'((9'(b0_s2) + 9'(b1_s2)) >> 1)};
			out_entry.cpal[3] = 24'd0;
		end

		case (fmt_s2)
			FMT_BC1: begin
				// punch-through: index 3 transparent in the three-color branch
				out_entry.apal    = {8{8'hFF}};
				out_entry.apal[3] = three_s2 ? 8'h00 : 8'hFF;
				out_entry.aidx    = 64'd0;
			end
			FMT_BC2: begin
				out_entry.apal = {8{8'hFF}};
				out_entry.aidx = aw_s2;
			end
			default: begin
				out_entry.apal[0] = aw_s2[7:0];
				out_entry.apal[1] = aw_s2[15:8];
				if (aw_s2[7:0] > aw_s2[15:8]) begin
					for (int i = 1; i <= 6; i++) begin
						out_entry.apal[i + 1] = div7(asum7_s2[i]);
					end
				end else begin
					for (int i = 1; i <= 4; i++) begin
						out_entry.apal[i + 1] = div5(asum5_s2[i]);
					end
					out_entry.apal[6] = 8'h00;
					out_entry.apal[7] = 8'hFF;
				end
				out_entry.aidx = {16'd0, aw_s2[63:16]};
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bcd_queue.sv =====
// Two-entry queue of decoded blocks between front and back end.
// Uses bcd_pkg for the entry type.
`default_nettype none

module bcd_queue
	import bcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire bcd_entry_t  in_entry,
	output logic             out_valid,
	input  wire logic        out_ready,
	output bcd_entry_t       out_entry
);

	bcd_entry_t  slot_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        push, pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_ready && out_valid;
	assign out_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_entry;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bcd_back.sv =====
// Back end: holds one decoded block and emits its 16 texels, one a cycle while
// out_ready does not stall it, into an output register. Uses bcd_pkg.
`default_nettype none

module bcd_back
	import bcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire bcd_entry_t  in_entry,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       texel_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic             last_texel
);

	bcd_entry_t  blk_q;
	logic        busy_q;
	logic [3:0]  cnt_q;
	logic        out_valid_q;

	logic        out_free, emit, done, load;
	logic [1:0]  ci;
	logic [3:0]  nib;
	logic [5:0]  a3_pos;
	logic [2:0]  ai;
	logic [23:0] rgb;
	logic [7:0]  a;

	assign out_free = !out_valid_q || out_ready;
	assign emit     = busy_q && out_free;
	assign done     = emit && (cnt_q == LAST_TEXEL);
	assign load     = in_valid && (!busy_q || done);
	assign in_ready = !busy_q || done;
	assign out_valid = out_valid_q;

	always_comb begin
		ci     = blk_q.cidx[{cnt_q, 1'b0} +: 2];
		nib    = blk_q.aidx[{cnt_q, 2'b00} +: 4];
		a3_pos = {1'b0, cnt_q, 1'b0} + {2'b00, cnt_q};
		ai     = blk_q.aidx[a3_pos +: 3];
		rgb    = blk_q.cpal[ci];
		case (blk_q.fmt)
			FMT_BC1: a = blk_q.apal[{1'b0, ci}];
			FMT_BC2: a = {nib, nib};
			default: a = blk_q.apal[ai];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)      busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (emit) cnt_q <= cnt_q + 4'd1;
			if (emit)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			blk_q <= in_entry;
		end
		if (emit) begin
			texel_index <= cnt_q;
			red         <= rgb[23:16];
			green       <= rgb[15:8];
			blue        <= rgb[7:0];
			alpha       <= a;
			last_texel  <= (cnt_q == LAST_TEXEL);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bc1_bc2_bc3_block_decoder.sv =====
// Top level of the BC1/BC2/BC3 texture block decoder: config registers,
// front end, block queue and texel back end. Uses bcd_pkg, bcd_front,
// bcd_queue, bcd_back.
//
//  port group   dir   word                                  accepted when
//  s_*          in    one 16-byte block                     s_tvalid & s_tready
//  m_*          out   one texel, tlast on texel 15          m_tvalid & m_tready
//  wr_*         in    register write (0 format, 1 swap)     wr_en
//
// A block yields 16 texels at one per cycle while m_tready does not stall the
// output, so the texel back end sets the rate, with no gap between blocks.
// The first texel of a block reaches m_tdata through front stage 1, front stage 2,
// the queue, the block register and the output register.
// Up to two decoded blocks wait in the queue; s_tready drops once it and both front
// stages are full. m_tready low holds the output and fills the queue.
// Reset clears all valid flags, the texel counter and the config registers.
`default_nettype none

module bc1_bc2_bc3_block_decoder
	import bcd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // block_low[63:0], block_high[127:64]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata,  // texel_index[3:0], red[11:4], green[19:12],
	                                    // blue[27:20], alpha[35:28], zero[39:36]
	output logic              m_tlast,
	input  wire logic         wr_en,
	input  wire logic         wr_index,
	input  wire logic [1:0]   wr_data
);

	logic [1:0] format_q;
	logic       swap_q;

	logic       f_valid, f_ready, b_valid, b_ready;
	bcd_entry_t f_entry, b_entry;
	logic [3:0] texel_index;
	logic [7:0] red, green, blue, alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_BC1;
			swap_q   <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_FORMAT: format_q <= wr_data;
				REG_SWAP:   swap_q   <= wr_data[0];
				default:    ;
			endcase
		end
	end

	bcd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_lo           (s_tdata[63:0]),
		.in_hi           (s_tdata[127:64]),
		.block_format    (format_q),
		.swap_byte_pairs (swap_q),
		.out_valid       (f_valid),
		.out_ready       (f_ready),
		.out_entry       (f_entry)
	);

	bcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_entry  (f_entry),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_entry (b_entry)
	);

	bcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (b_valid),
		.in_ready    (b_ready),
		.in_entry    (b_entry),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.texel_index (texel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.last_texel  (m_tlast)
	);

	assign m_tdata = {4'd0, alpha, blue, green, red, texel_index};

	// tlast marks exactly the sixteenth texel
	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[3:0] == LAST_TEXEL)))
		else $error("tlast does not match texel 15");

	// inside a block texels follow one another with no bubble
	a_no_gap_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1))
		else $error("texel sequence broken inside a block");

	// a block the queue cannot take stays on the front output, unchanged
	a_queue_flow: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid && $stable(f_entry))
		else $error("front end dropped or changed a waiting block");

endmodule

`default_nettype wire

// ===== test/bcd_texel_checker.sv =====
`timescale 1ns / 1ps
// Texel checker for the BC1/BC2/BC3 block decoder: watches the block, texel and
// register-write ports, decodes each accepted block itself and compares every texel.
// Depends on bcd_pkg for the format codes and register indexes.

module bcd_texel_checker
	import bcd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic         m_tlast,
	input  logic         wr_en,
	input  logic         wr_index,
	input  logic [1:0]   wr_data,
	output int           fail_count,
	output int           texels_due
);

	localparam int unsigned TRANSPARENT_IDX = 3;

	typedef struct packed {
		logic [3:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       is_last;
	} texel_t;

	texel_t      pending_texels[$];
	logic [1:0]  cur_fmt;
	logic        cur_swap;
	int          mismatches = 0;

	function automatic logic [63:0] pair_swapped(input logic [63:0] x);
		logic [63:0] y;
		for (int k = 0; k < 4; k++) begin
			y[16*k +: 8]   = x[16*k+8 +: 8];
			y[16*k+8 +: 8] = x[16*k +: 8];
		end
		return y;
	endfunction

	function automatic void widen_565(input logic [15:0] c, output int unsigned r,
			output int unsigned g, output int unsigned b);
		r = 32'(c[15:11]);
		g = 32'(c[10:5]);
		b = 32'(c[4:0]);
		r = r * 255 / 31;
		g = g * 255 / 63;
		b = b * 255 / 31;
	endfunction

	// Decodes one block under the given settings and queues its 16 texels.
	function automatic void decode_block(input logic [63:0] lo_in, input logic [63:0] hi_in,
			input logic [1:0] fmt, input logic swap);
		logic [63:0]  aw;
		logic [63:0]  cw;
		int unsigned  pr[4];
		int unsigned  pg[4];
		int unsigned  pb[4];
		int unsigned  pa[8];
		int unsigned  a0;
		int unsigned  a1;
		int unsigned  ci;
		int unsigned  al;
		logic         three;
		texel_t       t;
		aw = swap ? pair_swapped(lo_in) : lo_in;
		cw = (fmt == FMT_BC1) ? aw : (swap ? pair_swapped(hi_in) : hi_in);
		widen_565(cw[15:0], pr[0], pg[0], pb[0]);
		widen_565(cw[31:16], pr[1], pg[1], pb[1]);
		// punch-through only exists in BC1; BC2/BC3 always interpolate four colors
		three = (fmt == FMT_BC1) && (cw[15:0] <= cw[31:16]);
		if (three) begin
			pr[2] = (pr[0] + pr[1]) / 2;
			pg[2] = (pg[0] + pg[1]) / 2;
			pb[2] = (pb[0] + pb[1]) / 2;
			pr[3] = 0;
			pg[3] = 0;
			pb[3] = 0;
		end else begin
			pr[2] = (2 * pr[0] + pr[1]) / 3;
			pg[2] = (2 * pg[0] + pg[1]) / 3;
			pb[2] = (2 * pb[0] + pb[1]) / 3;
			pr[3] = (pr[0] + 2 * pr[1]) / 3;
			pg[3] = (pg[0] + 2 * pg[1]) / 3;
			pb[3] = (pb[0] + 2 * pb[1]) / 3;
		end
		a0 = 32'(aw[7:0]);
		a1 = 32'(aw[15:8]);
		pa[0] = a0;
		pa[1] = a1;
		if (a0 > a1) begin
			for (int k = 1; k < 7; k++)
				pa[k+1] = ((7 - k) * a0 + k * a1) / 7;
		end else begin
			for (int k = 1; k < 5; k++)
				pa[k+1] = ((5 - k) * a0 + k * a1) / 5;
			pa[6] = 0;
			pa[7] = 255;
		end
		for (int i = 0; i < 16; i++) begin
			ci = 32'(cw[32+2*i +: 2]);
			case (fmt)
				FMT_BC1: al = (three && ci == TRANSPARENT_IDX) ? 0 : 255;
				FMT_BC2: begin
					al = 32'(aw[4*i +: 4]);
					al = al * 255 / 15;
				end
				default: al = pa[aw[16+3*i +: 3]];  // BC3 and the spare code
			endcase
			t.idx     = 4'(i);
			t.red     = 8'(pr[ci]);
			t.green   = 8'(pg[ci]);
			t.blue    = 8'(pb[ci]);
			t.alpha   = 8'(al);
			t.is_last = (i == 15);
			pending_texels.insert(pending_texels.size(), t);
		end
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		texel_t want;
		if (!arst_n) begin
			cur_fmt  = FMT_BC1;
			cur_swap = 1'b0;
			pending_texels.delete();
			texels_due <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_texels.size() == 0) begin
					$error("texel word with no block pending: %h", m_tdata);
					mismatches++;
				end else begin
					want = pending_texels.pop_front();
					check_field("texel_index", 32'(want.idx), 32'(m_tdata[3:0]));
					check_field("red", 32'(want.red), 32'(m_tdata[11:4]));
					check_field("green", 32'(want.green), 32'(m_tdata[19:12]));
					check_field("blue", 32'(want.blue), 32'(m_tdata[27:20]));
					check_field("alpha", 32'(want.alpha), 32'(m_tdata[35:28]));
					check_field("last_texel", 32'(want.is_last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				decode_block(s_tdata[63:0], s_tdata[127:64], cur_fmt, cur_swap);
			if (wr_en) begin
				if (wr_index == REG_FORMAT)
					cur_fmt = wr_data;
				else
					cur_swap = wr_data[0];
			end
			texels_due <= pending_texels.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the BC1/BC2/BC3 block decoder: directed blocks, then
// random blocks under every format and swap setting, with random stalls on both sides.
// Depends on bcd_pkg, bc1_bc2_bc3_block_decoder and bcd_texel_checker.

module tb_top
	import bcd_pkg::*;
;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_AT_TEXEL = 1000;
	localparam int HOLD_CYCLES = 400;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;   // block_low[63:0], block_high[127:64]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;        // texel_index, red, green, blue, alpha, zero pad
	logic         m_tlast;
	logic         wr_en = 1'b0;
	logic         wr_index = 1'b0;
	logic [1:0]   wr_data = 2'd0;
	int           fail_count;
	int           texels_due;
	bit           tx_burst = 1'b0;

	bc1_bc2_bc3_block_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	bcd_texel_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.fail_count (fail_count),
		.texels_due (texels_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Texel sink: random stalls, bursts with none, and one long hold to back up the queue.
	initial begin
		int  stall;
		int  texels;
		bit  rx_burst;
		bit  held;
		texels   = 0;
		rx_burst = 1'b0;
		held     = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				rx_burst = !rx_burst;
			if (!held && texels >= HOLD_AT_TEXEL) begin
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end else begin
				stall = rx_burst ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			texels++;
		end
	end

	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
		int gap;
		if ($urandom_range(0, 15) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {hi, lo};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (texels_due != 0);
	endtask

	task automatic set_config(input logic [1:0] fmt, input logic swap);
		bit pad;
		pad = 1'($urandom_range(0, 1));
		wait_drained();
		wr_en    <= 1'b1;
		wr_index <= REG_FORMAT;
		wr_data  <= fmt;
		@(posedge clk);
		wr_index <= REG_SWAP;
		wr_data  <= {pad, swap};   // upper bit is don't-care for the swap register
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Random block, biased toward equal and extreme endpoints and equal alpha ends.
	task automatic make_random_block(input logic [1:0] fmt, output logic [63:0] lo,
			output logic [63:0] hi);
		logic [63:0] cw;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		cw = (fmt == FMT_BC1) ? lo : hi;
		case ($urandom_range(0, 7))
			0: cw[31:16] = cw[15:0];
			1: cw[31:0] = 32'h0000_FFFF;
			2: cw[31:0] = 32'hFFFF_0000;
			default: ;
		endcase
		if (fmt == FMT_BC1)
			lo = cw;
		else
			hi = cw;
		if ((fmt == FMT_BC3 || fmt == FMT_BC3_ALT) && $urandom_range(0, 3) == 0)
			lo[15:8] = lo[7:0];
	endtask

	initial begin
		logic [63:0] lo;
		logic [63:0] hi;
		logic [1:0]  fmt;
		logic        swap;
		int          n_blocks;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_config(FMT_BC1, 1'b0);
		send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, 64'h0);
		send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'h0);   // punch-through
		send_block({32'hFFFFFFFF, 16'h7BEF, 16'h7BEF}, 64'h0);   // equal ends, all clear
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block({32'h1B1B1B1B, 16'h07E0, 16'hF800}, '1);
		set_config(FMT_BC1, 1'b1);
		send_block({32'hE4E4E4E4, 16'h001F, 16'hF800}, 64'h0123456789ABCDEF);

		set_config(FMT_BC2, 1'b0);
		send_block(64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
		send_block(64'h0, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});   // ends reversed
		send_block('1, '1);

		set_config(FMT_BC3, 1'b0);
		send_block(64'hFAC688FAC68800FF, {32'hE4E4E4E4, 16'hF800, 16'h001F});  // 8-value ramp
		send_block(64'hFAC688FAC688FF00, {32'h1B1B1B1B, 16'h07E0, 16'hFFFF});  // 6-value ramp
		send_block(64'hFAC688FAC6888080, {32'hE4E4E4E4, 16'h8410, 16'h8410});
		send_block(64'h0, 64'h0);
		send_block('1, '1);

		set_config(FMT_BC3_ALT, 1'b0);
		send_block(64'hFAC688FAC68810F0, {32'h1B1B1B1B, 16'h1234, 16'hABCD});
		set_config(FMT_BC3_ALT, 1'b1);
		send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		set_config(FMT_BC2, 1'b1);
		send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);

		for (int p = 0; p < 8; p++) begin
			fmt  = 2'(p);
			swap = p[2];
			set_config(fmt, swap);
			n_blocks = $urandom_range(45, 55);
			repeat (n_blocks) begin
				make_random_block(fmt, lo, hi);
				send_block(lo, hi);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
